// ===== src/clp_pkg.sv =====
// Shared definitions for the colormap interpolation pixel unit:
// field widths, register and opcode codes, and the RGB entry type.
// No dependencies.
package clp_pkg;

  localparam int MAX_COLORS_DEF   = 256;
  localparam int SAMPLE_WIDTH_DEF = 16;

  localparam int CH_W       = 8;   // one color channel
  localparam int FRAC_W     = 8;   // fraction bits of a table position
  localparam int GAIN_W     = 32;
  localparam int OFFSET_W   = 32;
  localparam int COUNT_W    = 9;
  localparam int IDX_W      = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN        = 2'd0,
    REG_OFFSET      = 2'd1,
    REG_COLOR_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

endpackage

// ===== src/clp_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while the read enable is low. No dependencies.
module clp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/clp_blend.sv =====
// Linear blend of two neighboring table entries, all three channels.
// Depends on clp_pkg (rgb_t, widths).
module clp_blend (
  input  clp_pkg::rgb_t                    c0,
  input  clp_pkg::rgb_t                    c1,
  input  logic [clp_pkg::FRAC_W-1:0]       t,
  input  logic                             last,
  output clp_pkg::rgb_t                    color
);

  localparam int WT_W  = clp_pkg::FRAC_W + 1;
  localparam int ACC_W = WT_W + clp_pkg::CH_W;

  // ((256 - t) * a + t * b) >> 8; never exceeds 256 * 255
  function automatic logic [clp_pkg::CH_W-1:0] lerp(
    input logic [clp_pkg::CH_W-1:0]   a,
    input logic [clp_pkg::CH_W-1:0]   b,
    input logic [clp_pkg::FRAC_W-1:0] w
  );
    logic [WT_W-1:0]  w0;
    logic [ACC_W-1:0] acc;
    w0  = WT_W'(1 << clp_pkg::FRAC_W) - WT_W'(w);
    acc = ACC_W'(w0) * ACC_W'(a) + ACC_W'(w) * ACC_W'(b);
    return acc[clp_pkg::FRAC_W +: clp_pkg::CH_W];
  endfunction

  always_comb begin
    if (last) begin
      color = c0;
    end else begin
      color.red   = lerp(c0.red,   c1.red,   t);
      color.green = lerp(c0.green, c1.green, t);
      color.blue  = lerp(c0.blue,  c1.blue,  t);
    end
  end

endmodule

// ===== src/colormap_lerp_pixel.sv =====
// Pseudo-color unit: a write item (opcode 0) loads one RGB entry of the color table, a sample
// item (opcode 1) maps a signed sample to position ((gain*sample)>>8)+offset in Q.8, clamps it
// to [0,(count-1)<<8] and blends entries q and q+1 by the fraction; the last entry is passed
// through unchanged. One item is accepted per clock unless the output stalls; a sample's color
// is registered as product (at the transfer edge), then as clamped position, table read data
// and blended color; write items give no output. The table is held twice, in two RAMs written
// together, so both neighbors are read in the same cycle.
// Entries come up undefined after reset and have no clearing pass: write before use. A stalled
// output holds the whole pipeline, so in_ready follows out_ready while a color waits.
// Depends on clp_pkg, clp_ram and clp_blend.
module colormap_lerp_pixel #(
  parameter int MAX_COLORS   = clp_pkg::MAX_COLORS_DEF,
  parameter int SAMPLE_WIDTH = clp_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [clp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [clp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [clp_pkg::IDX_W-1:0]           in_entry_index,
  input  logic [clp_pkg::CH_W-1:0]            in_entry_red,
  input  logic [clp_pkg::CH_W-1:0]            in_entry_green,
  input  logic [clp_pkg::CH_W-1:0]            in_entry_blue,
  input  logic signed [SAMPLE_WIDTH-1:0]      in_sample,
  // colored results
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clp_pkg::CH_W-1:0]            out_red,
  output logic [clp_pkg::CH_W-1:0]            out_green,
  output logic [clp_pkg::CH_W-1:0]            out_blue
);

  localparam int ADDR_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int PROD_W = clp_pkg::GAIN_W + SAMPLE_WIDTH;
  localparam int SUM_W  = PROD_W - clp_pkg::FRAC_W + 1;
  localparam int POS_W  = ADDR_W + clp_pkg::FRAC_W;
  localparam int CMP_W  = (ADDR_W + 1 > clp_pkg::COUNT_W) ? ADDR_W + 1 : clp_pkg::COUNT_W;
  localparam int RGB_W  = $bits(clp_pkg::rgb_t);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [clp_pkg::GAIN_W-1:0]   cfg_gain_r,   cfg_gain_nxt;
  logic signed [clp_pkg::OFFSET_W-1:0] cfg_offset_r, cfg_offset_nxt;
  logic [clp_pkg::COUNT_W-1:0]         cfg_count_r,  cfg_count_nxt;

  always_comb begin
    cfg_gain_nxt   = cfg_gain_r;
    cfg_offset_nxt = cfg_offset_r;
    cfg_count_nxt  = cfg_count_r;
    if (cfg_we) begin
      case (clp_pkg::cfg_reg_t'(cfg_index))
        clp_pkg::REG_GAIN:        cfg_gain_nxt   = cfg_data[clp_pkg::GAIN_W-1:0];
        clp_pkg::REG_OFFSET:      cfg_offset_nxt = cfg_data[clp_pkg::OFFSET_W-1:0];
        clp_pkg::REG_COLOR_COUNT: cfg_count_nxt  = cfg_data[clp_pkg::COUNT_W-1:0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_gain_r   <= '0;
      cfg_offset_r <= '0;
      cfg_count_r  <= clp_pkg::COUNT_W'(2);
    end else begin
      cfg_gain_r   <= cfg_gain_nxt;
      cfg_offset_r <= cfg_offset_nxt;
      cfg_count_r  <= cfg_count_nxt;
    end
  end

  // Last usable entry: count clamped to [2, MAX_COLORS], minus one.
  logic [CMP_W-1:0]  cnt_ext;
  logic [ADDR_W-1:0] last_idx;
  logic [POS_W-1:0]  pos_top;

  always_comb begin
    cnt_ext = CMP_W'(cfg_count_r);
    if (cnt_ext < CMP_W'(2)) begin
      last_idx = ADDR_W'(1);
    end else if (cnt_ext > CMP_W'(MAX_COLORS)) begin
      last_idx = ADDR_W'(MAX_COLORS - 1);
    end else begin
      last_idx = ADDR_W'(cnt_ext - CMP_W'(1));
    end
    pos_top = {last_idx, {clp_pkg::FRAC_W{1'b0}}};
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: everything advances unless a finished color is waiting
  // ---------------------------------------------------------------------------
  logic advance;
  logic out_valid_r, out_valid_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;

  // Stage 1: multiply
  logic                            s1_valid_r, s1_valid_nxt;
  logic                            s1_op_r;
  logic [clp_pkg::IDX_W-1:0]       s1_idx_r;
  clp_pkg::rgb_t                   s1_rgb_r;
  logic signed [PROD_W-1:0]        s1_prod_r, s1_prod_nxt;

  // Stage 2: clamped position, table access issued from here
  logic                            s2_valid_r, s2_valid_nxt;
  logic                            s2_op_r;
  logic [clp_pkg::IDX_W-1:0]       s2_idx_r;
  clp_pkg::rgb_t                   s2_rgb_r;
  logic [ADDR_W-1:0]               s2_q_r,    s2_q_nxt;
  logic [clp_pkg::FRAC_W-1:0]      s2_t_r,    s2_t_nxt;
  logic                            s2_last_r, s2_last_nxt;

  // Stage 3: table data available
  logic                            s3_valid_r, s3_valid_nxt;
  logic                            s3_op_r;
  logic [clp_pkg::FRAC_W-1:0]      s3_t_r;
  logic                            s3_last_r;

  // Output register
  clp_pkg::rgb_t                   out_rgb_r, out_rgb_nxt;

  logic signed [SUM_W-1:0]         pos_sum;
  logic [POS_W-1:0]                pos_clamp;

  assign s1_prod_nxt = PROD_W'(cfg_gain_r) * PROD_W'(in_sample);

  always_comb begin
    // floor((gain*sample)/256) is an arithmetic shift
    pos_sum = SUM_W'(s1_prod_r >>> clp_pkg::FRAC_W) + SUM_W'(cfg_offset_r);
    if (pos_sum[SUM_W-1]) begin
      pos_clamp = '0;
    end else if ($unsigned(pos_sum) > SUM_W'(pos_top)) begin
      pos_clamp = pos_top;
    end else begin
      pos_clamp = pos_sum[POS_W-1:0];
    end
    s2_q_nxt    = pos_clamp[POS_W-1:clp_pkg::FRAC_W];
    s2_t_nxt    = pos_clamp[clp_pkg::FRAC_W-1:0];
    s2_last_nxt = (s2_q_nxt == last_idx);
  end

  always_comb begin
    s1_valid_nxt  = in_valid;
    s2_valid_nxt  = s1_valid_r;
    s3_valid_nxt  = s2_valid_r;
    out_valid_nxt = s3_valid_r && (s3_op_r == clp_pkg::OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r   <= in_opcode;
      s1_idx_r  <= in_entry_index;
      s1_rgb_r  <= '{red: in_entry_red, green: in_entry_green, blue: in_entry_blue};
      s1_prod_r <= s1_prod_nxt;

      s2_op_r   <= s1_op_r;
      s2_idx_r  <= s1_idx_r;
      s2_rgb_r  <= s1_rgb_r;
      s2_q_r    <= s2_q_nxt;
      s2_t_r    <= s2_t_nxt;
      s2_last_r <= s2_last_nxt;

      s3_op_r   <= s2_op_r;
      s3_t_r    <= s2_t_r;
      s3_last_r <= s2_last_r;

      out_rgb_r <= out_rgb_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Color table: two copies, same writes, one read port each
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic              idx_in_range;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] raddr_lo, raddr_hi;
  logic [RGB_W-1:0]  rdata_lo, rdata_hi;

  // Writes and reads issue from the same stage, so a sample always sees
  // every write transferred before it; no forwarding needed.
  assign idx_in_range = (32'(s2_idx_r) < 32'(MAX_COLORS));
  assign ram_we       = advance && s2_valid_r && (s2_op_r == clp_pkg::OP_WRITE) && idx_in_range;
  assign ram_waddr    = ADDR_W'(s2_idx_r);
  assign raddr_lo     = s2_q_r;
  // at the last entry the upper neighbor is unused; keep the address in range
  assign raddr_hi     = s2_last_r ? s2_q_r : s2_q_r + ADDR_W'(1);

  clp_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_COLORS),
    .AW    (ADDR_W)
  ) u_ram_lo (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s2_rgb_r),
    .re    (advance),
    .raddr (raddr_lo),
    .rdata (rdata_lo)
  );

  clp_ram #(
    .WIDTH (RGB_W),
    .DEPTH (MAX_COLORS),
    .AW    (ADDR_W)
  ) u_ram_hi (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (s2_rgb_r),
    .re    (advance),
    .raddr (raddr_hi),
    .rdata (rdata_hi)
  );

  // ---------------------------------------------------------------------------
  // Blend and output
  // ---------------------------------------------------------------------------
  clp_blend u_blend (
    .c0    (clp_pkg::rgb_t'(rdata_lo)),
    .c1    (clp_pkg::rgb_t'(rdata_hi)),
    .t     (s3_t_r),
    .last  (s3_last_r),
    .color (out_rgb_nxt)
  );

  assign out_valid = out_valid_r;
  assign out_red   = out_rgb_r.red;
  assign out_green = out_rgb_r.green;
  assign out_blue  = out_rgb_r.blue;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // The last entry is reached only at the clamp ceiling, so its fraction is zero.
  a_last_no_frac: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && (s2_op_r == clp_pkg::OP_SAMPLE) && s2_last_r |-> s2_t_r == '0)
    else $error("last entry selected with nonzero fraction");

  // The table position never passes the last entry in use.
  a_q_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && (s2_op_r == clp_pkg::OP_SAMPLE) |-> s2_q_r <= last_idx)
    else $error("table index beyond color count");

  // A held pipeline must not write the table twice.
  a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |-> !ram_we)
    else $error("table write while pipeline stalled");

  // A sample leaving the table stage always becomes an output.
  a_sample_emerges: assert property (@(posedge clk) disable iff (!rst_n)
    advance && s3_valid_r && (s3_op_r == clp_pkg::OP_SAMPLE) |=> out_valid_r)
    else $error("sample lost between table read and output");

endmodule
